>>> src/lbfe_pkg.sv
package lbfe_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_BLINK = 2'd1,
		CMD_FADE  = 2'd2,
		CMD_OFF   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CALC,
		ST_RESULT
	} state_t;

	typedef enum logic [1:0] {
		SCL_IDLE,
		SCL_MUL,
		SCL_DIV
	} scl_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} scl_stat_t;

	localparam int unsigned BLINK_LIMIT  = 10001;
	localparam int unsigned FADE_LIMIT   = 10000;
	localparam int unsigned RESET_LENGTH = 100;

endpackage

>>> src/lbfe_in_if.sv
interface lbfe_in_if #(
	parameter int LEVEL_BITS    = 10,
	parameter int DURATION_BITS = 14
);
	logic                     valid;
	logic                     ready;
	logic [1:0]               command;
	logic [LEVEL_BITS-1:0]    level_a;
	logic [LEVEL_BITS-1:0]    level_b;
	logic [DURATION_BITS-1:0] duration_ms;
	logic                     has_level_a;
	logic                     has_level_b;
	logic                     has_duration;

	modport source (
		output valid, command, level_a, level_b, duration_ms,
		output has_level_a, has_level_b, has_duration,
		input  ready
	);
	modport sink (
		input  valid, command, level_a, level_b, duration_ms,
		input  has_level_a, has_level_b, has_duration,
		output ready
	);
endinterface

>>> src/lbfe_out_if.sv
interface lbfe_out_if #(
	parameter int LEVEL_BITS = 10
);
	logic                  valid;
	logic                  ready;
	logic [LEVEL_BITS-1:0] level;
	logic                  drive;

	modport source (output valid, level, drive, input ready);
	modport sink (input valid, level, drive, output ready);
endinterface

>>> src/led_blink_fade_envelope_top.sv
// Off, start blink, start fade and a tick that drives nothing: result valid the cycle after.
// Tick with a driving envelope: the result goes through ST_LOAD, ST_CALC and ST_RESULT, set by
// the shared multiply and bit-serial divider, one quotient bit per cycle.
// One item at a time; the next transfer is taken once the result is registered and the output is free or being read.
// arst_n clears levels to 0 / full scale, lengths to 100 and both envelopes to idle.
module led_blink_fade_envelope_top #(
	parameter int LEVEL_BITS    = 10,
	parameter int DURATION_BITS = 14
) (
	input logic         clk,
	input logic         arst_n,
	lbfe_in_if.sink     req,
	lbfe_out_if.source  rsp
);
	localparam int L = LEVEL_BITS;
	localparam int D = DURATION_BITS;
	localparam logic [D-1:0] DUR_MAX = '1;

	lbfe_pkg::state_t    state_q, state_n;
	lbfe_pkg::cmd_t      cmd;
	lbfe_pkg::scl_stat_t stat;

	logic [L-1:0] low_q, high_q;
	logic [D-1:0] blink_len_q, fade_len_q;
	logic         blink_act_q, fade_act_q, fade_down_q;
	logic [D-1:0] blink_el_q, fade_el_q;
	logic         use_blink_q;
	logic [L-1:0] res_q;
	logic         out_valid_q, out_drive_q;
	logic [L-1:0] out_level_q;

	logic         accept, load_out, scl_start;
	logic [D-1:0] fade_el_n, blink_el_n;
	logic         fade_end, blink_end, fade_drv, blink_drv;
	logic [L-1:0] from_n, to_n, blink_low_n;
	logic [D-1:0] sel_len, sel_el, num;
	logic [D:0]   twice, num_raw;
	logic [L-1:0] diff, quot;

	assign cmd = lbfe_pkg::cmd_t'(req.command);

	always_comb begin
		fade_el_n  = (fade_el_q < DUR_MAX) ? fade_el_q + 1'b1 : fade_el_q;
		blink_el_n = (blink_el_q < DUR_MAX) ? blink_el_q + 1'b1 : blink_el_q;
		fade_end   = fade_act_q && (fade_el_n > fade_len_q);
		blink_end  = blink_act_q && (blink_el_n > blink_len_q);
		fade_drv   = fade_act_q && !fade_end;
		blink_drv  = blink_act_q && !blink_end;

		blink_low_n = (req.has_level_a && (req.level_a < high_q)) ? req.level_a : low_q;

		from_n = fade_down_q ? high_q : low_q;
		to_n   = fade_down_q ? low_q : high_q;
		if (req.has_level_a) from_n = req.level_a;
		if (req.has_level_b) to_n = req.level_b;
	end

	always_comb begin
		sel_len = use_blink_q ? blink_len_q : fade_len_q;
		sel_el  = use_blink_q ? blink_el_q : fade_el_q;
		twice   = {sel_el, 1'b0};
		if (use_blink_q)
			num_raw = (twice < {1'b0, sel_len}) ? {1'b0, sel_len} - twice
			                                   : twice - {1'b0, sel_len};
		else if (fade_down_q)
			num_raw = {1'b0, sel_len - sel_el};
		else
			num_raw = {1'b0, sel_el};
		num  = (num_raw > {1'b0, sel_len}) ? sel_len : num_raw[D-1:0];
		diff = (high_q >= low_q) ? high_q - low_q : '0;
	end

	lbfe_scale #(
		.LEVEL_BITS   (L),
		.DURATION_BITS(D)
	) u_scale (
		.clk   (clk),
		.arst_n(arst_n),
		.start (scl_start),
		.diff  (diff),
		.num   (num),
		.len   (sel_len),
		.quot  (quot),
		.stat  (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lbfe_pkg::ST_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n   = state_q;
		req.ready = 1'b0;
		accept    = 1'b0;
		load_out  = 1'b0;
		scl_start = 1'b0;
		unique case (state_q)
			lbfe_pkg::ST_IDLE: begin
				req.ready = !out_valid_q || rsp.ready;
				accept    = req.valid && req.ready;
				if (accept) begin
					if (cmd == lbfe_pkg::CMD_TICK && (fade_drv || blink_drv))
						state_n = lbfe_pkg::ST_LOAD;
					else
						load_out = 1'b1;
				end
			end
			lbfe_pkg::ST_LOAD: begin
				if (sel_len == '0) begin
					state_n = lbfe_pkg::ST_RESULT;
				end else begin
					scl_start = 1'b1;
					state_n   = lbfe_pkg::ST_CALC;
				end
			end
			lbfe_pkg::ST_CALC: begin
				if (stat.done) state_n = lbfe_pkg::ST_RESULT;
			end
			lbfe_pkg::ST_RESULT: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_n  = lbfe_pkg::ST_IDLE;
				end
			end
			default: state_n = lbfe_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q       <= '0;
			high_q      <= '1;
			blink_len_q <= D'(lbfe_pkg::RESET_LENGTH);
			fade_len_q  <= D'(lbfe_pkg::RESET_LENGTH);
			blink_act_q <= 1'b0;
			fade_act_q  <= 1'b0;
			fade_down_q <= 1'b0;
			blink_el_q  <= '0;
			fade_el_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;

			if (accept) begin
				unique case (cmd)
					lbfe_pkg::CMD_TICK: begin
						if (fade_act_q) begin
							fade_el_q <= fade_el_n;
							if (fade_end) fade_act_q <= 1'b0;
						end
						if (blink_act_q) begin
							blink_el_q <= blink_el_n;
							if (blink_end) blink_act_q <= 1'b0;
						end
					end
					lbfe_pkg::CMD_BLINK: begin
						low_q <= blink_low_n;
						if (req.has_level_b && (req.level_b > blink_low_n))
							high_q <= req.level_b;
						if (req.has_duration && (req.duration_ms != '0) &&
						    (32'(req.duration_ms) < lbfe_pkg::BLINK_LIMIT))
							blink_len_q <= req.duration_ms;
						blink_act_q <= 1'b1;
						blink_el_q  <= '0;
					end
					lbfe_pkg::CMD_FADE: begin
						if (from_n > to_n) begin
							fade_down_q <= 1'b1;
							high_q      <= from_n;
							low_q       <= to_n;
						end else begin
							fade_down_q <= 1'b0;
							high_q      <= to_n;
							low_q       <= from_n;
						end
						if (req.has_duration && (req.duration_ms != '0) &&
						    (32'(req.duration_ms) < lbfe_pkg::FADE_LIMIT))
							fade_len_q <= req.duration_ms;
						fade_act_q <= 1'b1;
						fade_el_q  <= '0;
					end
					lbfe_pkg::CMD_OFF: begin
						blink_act_q <= 1'b0;
						fade_act_q  <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			use_blink_q <= blink_drv;
		if (state_q == lbfe_pkg::ST_LOAD)
			res_q <= high_q;
		else if (state_q == lbfe_pkg::ST_CALC && stat.done)
			res_q <= low_q + quot;
		if (load_out) begin
			if (state_q == lbfe_pkg::ST_RESULT) begin
				out_level_q <= res_q;
				out_drive_q <= 1'b1;
			end else begin
				out_level_q <= '0;
				out_drive_q <= (cmd == lbfe_pkg::CMD_OFF);
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.level = out_level_q;
	assign rsp.drive = out_drive_q;

	a_levels_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		low_q <= high_q) else $error("low level above high level");

	a_blink_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		blink_act_q |-> blink_el_q <= blink_len_q) else $error("blink past its length");

	a_fade_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fade_act_q |-> fade_el_q <= fade_len_q) else $error("fade past its length");

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> state_q == lbfe_pkg::ST_CALC) else $error("divider done out of turn");

	a_calc_has_unit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lbfe_pkg::ST_CALC |-> stat.busy || stat.done)
		else $error("waiting on an idle divider");

endmodule

>>> src/lbfe_scale.sv
// diff * num / len, one multiply then one quotient bit per cycle.
// Caller keeps num <= len and len > 0, so the quotient fits LEVEL_BITS.
module lbfe_scale #(
	parameter int LEVEL_BITS    = 10,
	parameter int DURATION_BITS = 14
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [LEVEL_BITS-1:0]    diff,
	input  logic [DURATION_BITS-1:0] num,
	input  logic [DURATION_BITS-1:0] len,
	output logic [LEVEL_BITS-1:0]    quot,
	output lbfe_pkg::scl_stat_t      stat
);
	localparam int L     = LEVEL_BITS;
	localparam int D     = DURATION_BITS;
	localparam int CNT_W = $clog2(LEVEL_BITS);

	lbfe_pkg::scl_state_t state_q, state_n;

	logic [L-1:0]     diff_q;
	logic [D-1:0]     num_q;
	logic [D-1:0]     len_q;
	logic [D-1:0]     rem_q;
	logic [L-1:0]     acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic [L+D-1:0]   prod;
	logic [D:0]       trial;
	logic             ge;

	assign prod  = (L+D)'(diff_q) * (L+D)'(num_q);
	assign trial = {rem_q, acc_q[L-1]};
	assign ge    = trial >= {1'b0, len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbfe_pkg::SCL_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= (state_q == lbfe_pkg::SCL_DIV) && (cnt_q == '0);
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			lbfe_pkg::SCL_IDLE: if (start) state_n = lbfe_pkg::SCL_MUL;
			lbfe_pkg::SCL_MUL:  state_n = lbfe_pkg::SCL_DIV;
			lbfe_pkg::SCL_DIV:  if (cnt_q == '0) state_n = lbfe_pkg::SCL_IDLE;
			default:            state_n = lbfe_pkg::SCL_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lbfe_pkg::SCL_IDLE: begin
				if (start) begin
					diff_q <= diff;
					num_q  <= num;
					len_q  <= len;
				end
			end
			lbfe_pkg::SCL_MUL: begin
				rem_q <= prod[L+D-1:L];
				acc_q <= prod[L-1:0];
				cnt_q <= CNT_W'(L - 1);
			end
			lbfe_pkg::SCL_DIV: begin
				rem_q <= ge ? D'(trial - {1'b0, len_q}) : trial[D-1:0];
				acc_q <= {acc_q[L-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	assign quot      = acc_q;
	assign stat.busy = state_q != lbfe_pkg::SCL_IDLE;
	assign stat.done = done_q;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int LVL_W = 10;
	localparam int DUR_W = 14;
	localparam logic [DUR_W-1:0] DUR_MAX = '1;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned HOLD_CYCLES = 300;

	typedef struct packed {
		lbfe_pkg::cmd_t   command;
		logic [LVL_W-1:0] level_a;
		logic [LVL_W-1:0] level_b;
		logic [DUR_W-1:0] duration_ms;
		logic             has_level_a;
		logic             has_level_b;
		logic             has_duration;
	} item_t;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic             drive;
	} env_out_t;

	typedef struct packed {
		lbfe_pkg::cmd_t   cmd;
		logic [LVL_W-1:0] a;
		logic [LVL_W-1:0] b;
		logic [DUR_W-1:0] d;
		logic             ha;
		logic             hb;
		logic             hd;
		logic             known;
		logic [LVL_W-1:0] want_level;
		logic             want_drive;
	} step_t;

	logic clk;
	logic arst_n;

	lbfe_in_if #(.LEVEL_BITS(LVL_W), .DURATION_BITS(DUR_W)) req_if ();
	lbfe_out_if #(.LEVEL_BITS(LVL_W)) rsp_if ();

	led_blink_fade_envelope_top #(
		.LEVEL_BITS(LVL_W),
		.DURATION_BITS(DUR_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	// envelope state mirror
	logic [LVL_W-1:0] lo_lvl  = '0;
	logic [LVL_W-1:0] hi_lvl  = '1;
	logic [DUR_W-1:0] blk_len = DUR_W'(lbfe_pkg::RESET_LENGTH);
	logic [DUR_W-1:0] fd_len  = DUR_W'(lbfe_pkg::RESET_LENGTH);
	logic             blk_on  = 1'b0;
	logic             fd_on   = 1'b0;
	logic             fd_down = 1'b0;
	logic [DUR_W-1:0] blk_t   = '0;
	logic [DUR_W-1:0] fd_t    = '0;

	env_out_t    levels_due [$];
	int unsigned mismatches   = 0;
	int unsigned src_idle_pct = 10;
	int unsigned snk_idle_pct = 54;
	bit          hold_req     = 1'b0;

	// directed opening: known = 1 rows carry the result typed in
	step_t opening_steps [25] = '{
		'{lbfe_pkg::CMD_TICK,     0,    0,     0, 0, 0, 0, 1,    0, 0},
		'{lbfe_pkg::CMD_OFF,      0,    0,     0, 0, 0, 0, 1,    0, 1},
		'{lbfe_pkg::CMD_FADE,   512,  256,     1, 0, 0, 1, 1,    0, 0},
		'{lbfe_pkg::CMD_TICK,     0,    0,     0, 0, 0, 0, 1, 1023, 1},
		'{lbfe_pkg::CMD_TICK,     0,    0,     0, 0, 0, 0, 1,    0, 0},
		'{lbfe_pkg::CMD_BLINK, 1023,    0,     0, 1, 1, 1, 1,    0, 0},
		'{lbfe_pkg::CMD_TICK,     0,    0,     0, 0, 0, 0, 0,    0, 0},
		'{lbfe_pkg::CMD_OFF,   1023, 1023, 16383, 1, 1, 1, 1,    0, 1},
		'{lbfe_pkg::CMD_BLINK,    0, 1023, 10001, 1, 1, 1, 1,    0, 0},
		'{lbfe_pkg::CMD_BLINK,    0, 1023, 10000, 1, 1, 1, 1,    0, 0},
		'{lbfe_pkg::CMD_TICK,  1023, 1023, 16383, 1, 1, 1, 0,    0, 0},
		'{lbfe_pkg::CMD_BLINK,  100,  900,     2, 1, 1, 1, 1,    0, 0},
		'{lbfe_pkg::CMD_TICK,     0,    0,     0, 0, 0, 0, 0,    0, 0},
		'{lbfe_pkg::CMD_TICK,     0,    0,     0, 0, 0, 0, 0,    0, 0},
		'{lbfe_pkg::CMD_TICK,     0,    0,     0, 0, 0, 0, 1,    0, 0},
		'{lbfe_pkg::CMD_FADE,  1023,    0,  9999, 1, 1, 1, 1,    0, 0},
		'{lbfe_pkg::CMD_FADE,     0,  512, 10000, 0, 1, 1, 1,    0, 0},
		'{lbfe_pkg::CMD_TICK,     0,    0,     0, 0, 0, 0, 0,    0, 0},
		'{lbfe_pkg::CMD_FADE,   300,    0, 16383, 1, 0, 1, 1,    0, 0},
		'{lbfe_pkg::CMD_BLINK,  400,  450,     3, 1, 1, 1, 1,    0, 0},
		'{lbfe_pkg::CMD_TICK,     0,    0,     0, 0, 0, 0, 0,    0, 0},
		'{lbfe_pkg::CMD_FADE,   700,  700,     1, 1, 1, 1, 1,    0, 0},
		'{lbfe_pkg::CMD_TICK,     0,    0,     0, 0, 0, 0, 0,    0, 0},
		'{lbfe_pkg::CMD_OFF,      0,    0,     0, 0, 0, 0, 1,    0, 1},
		'{lbfe_pkg::CMD_FADE,     0,    0,     0, 0, 0, 0, 1,    0, 0}
	};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic [LVL_W-1:0] ramp_level(int unsigned num, int unsigned span);
		int unsigned diff;
		diff = (hi_lvl >= lo_lvl) ? 32'(hi_lvl - lo_lvl) : 32'd0;
		if (span == 0)
			return hi_lvl;
		if (num > span)
			num = span;
		return LVL_W'(32'(lo_lvl) + diff * num / span);
	endfunction

	function automatic env_out_t envelope_step(item_t it);
		env_out_t         r;
		int unsigned      num;
		int unsigned      twice;
		logic [LVL_W-1:0] from_l;
		logic [LVL_W-1:0] to_l;
		r = '0;
		case (it.command)
			lbfe_pkg::CMD_TICK: begin
				if (fd_on) begin
					fd_t = (fd_t < DUR_MAX) ? fd_t + 1'b1 : DUR_MAX;
					if (fd_t > fd_len) begin
						fd_on = 1'b0;
					end else begin
						num = 32'(fd_down ? fd_len - fd_t : fd_t);
						r.level = ramp_level(num, 32'(fd_len));
						r.drive = 1'b1;
					end
				end
				// blink overrides fade on the same tick
				if (blk_on) begin
					blk_t = (blk_t < DUR_MAX) ? blk_t + 1'b1 : DUR_MAX;
					if (blk_t > blk_len) begin
						blk_on = 1'b0;
					end else begin
						twice = 2 * 32'(blk_t);
						num = (twice < 32'(blk_len)) ? 32'(blk_len) - twice
						                             : twice - 32'(blk_len);
						r.level = ramp_level(num, 32'(blk_len));
						r.drive = 1'b1;
					end
				end
			end
			lbfe_pkg::CMD_BLINK: begin
				if (it.has_level_a && it.level_a < hi_lvl)
					lo_lvl = it.level_a;
				if (it.has_level_b && it.level_b > lo_lvl)
					hi_lvl = it.level_b;
				if (it.has_duration && it.duration_ms != '0 &&
				    32'(it.duration_ms) < lbfe_pkg::BLINK_LIMIT)
					blk_len = it.duration_ms;
				blk_on = 1'b1;
				blk_t = '0;
			end
			lbfe_pkg::CMD_FADE: begin
				from_l = fd_down ? hi_lvl : lo_lvl;
				to_l = fd_down ? lo_lvl : hi_lvl;
				if (it.has_level_a)
					from_l = it.level_a;
				if (it.has_level_b)
					to_l = it.level_b;
				fd_down = from_l > to_l;
				hi_lvl = fd_down ? from_l : to_l;
				lo_lvl = fd_down ? to_l : from_l;
				if (it.has_duration && it.duration_ms != '0 &&
				    32'(it.duration_ms) < lbfe_pkg::FADE_LIMIT)
					fd_len = it.duration_ms;
				fd_on = 1'b1;
				fd_t = '0;
			end
			lbfe_pkg::CMD_OFF: begin
				blk_on = 1'b0;
				fd_on = 1'b0;
				r.drive = 1'b1;
			end
		endcase
		return r;
	endfunction

	task automatic send_item(input item_t it, input logic known, input env_out_t want);
		while ($urandom_range(99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.command      <= it.command;
		req_if.level_a      <= it.level_a;
		req_if.level_b      <= it.level_b;
		req_if.duration_ms  <= it.duration_ms;
		req_if.has_level_a  <= it.has_level_a;
		req_if.has_level_b  <= it.has_level_b;
		req_if.has_duration <= it.has_duration;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		want = known ? want : envelope_step(it);
		if (known)
			void'(envelope_step(it));
		levels_due.push_back(want);
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		wait (levels_due.size() == 0);
		@(posedge clk);
	endtask

	function automatic item_t rand_item();
		item_t it;
		it.command      = lbfe_pkg::cmd_t'($urandom_range(3));
		it.level_a      = LVL_W'($urandom);
		it.level_b      = LVL_W'($urandom);
		it.duration_ms  = DUR_W'($urandom);
		it.has_level_a  = 1'($urandom_range(1));
		it.has_level_b  = 1'($urandom_range(1));
		it.has_duration = 1'($urandom_range(1));
		return it;
	endfunction

	function automatic logic [LVL_W-1:0] pick_level();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return LVL_W'($urandom);
		endcase
	endfunction

	function automatic logic [DUR_W-1:0] pick_duration();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 75)
			return DUR_W'($urandom_range(1, 30));
		if (r < 85) begin
			case ($urandom_range(4))
				0: return '0;
				1: return DUR_W'(lbfe_pkg::FADE_LIMIT - 1);
				2: return DUR_W'(lbfe_pkg::FADE_LIMIT);
				3: return DUR_W'(lbfe_pkg::BLINK_LIMIT);
				default: return '1;
			endcase
		end
		return DUR_W'($urandom);
	endfunction

	// mostly start / tick-run sequences, some overlapping, the rest noise
	task automatic random_phase(input int n);
		item_t it;
		int    sent;
		int    starts;
		int    ticks;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(99) < 80) begin
				starts = ($urandom_range(3) == 0) ? 2 : 1;
				repeat (starts) begin
					it = rand_item();
					it.command      = $urandom_range(1) ? lbfe_pkg::CMD_BLINK
					                                    : lbfe_pkg::CMD_FADE;
					it.level_a      = pick_level();
					it.level_b      = pick_level();
					it.duration_ms  = pick_duration();
					it.has_level_a  = ($urandom_range(9) != 0);
					it.has_level_b  = ($urandom_range(9) != 0);
					it.has_duration = ($urandom_range(9) != 0);
					send_item(it, 1'b0, '0);
					sent++;
				end
				ticks = $urandom_range(1, 34);
				repeat (ticks) begin
					it = rand_item();
					it.command = lbfe_pkg::CMD_TICK;
					send_item(it, 1'b0, '0);
					sent++;
				end
				if ($urandom_range(3) == 0) begin
					it = rand_item();
					it.command = lbfe_pkg::CMD_OFF;
					send_item(it, 1'b0, '0);
					sent++;
				end
			end else begin
				send_item(rand_item(), 1'b0, '0);
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		item_t    it;
		env_out_t want;
		req_if.valid        <= 1'b0;
		req_if.command      <= lbfe_pkg::CMD_TICK;
		req_if.level_a      <= '0;
		req_if.level_b      <= '0;
		req_if.duration_ms  <= '0;
		req_if.has_level_a  <= 1'b0;
		req_if.has_level_b  <= 1'b0;
		req_if.has_duration <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);

		foreach (opening_steps[i]) begin
			it.command      = opening_steps[i].cmd;
			it.level_a      = opening_steps[i].a;
			it.level_b      = opening_steps[i].b;
			it.duration_ms  = opening_steps[i].d;
			it.has_level_a  = opening_steps[i].ha;
			it.has_level_b  = opening_steps[i].hb;
			it.has_duration = opening_steps[i].hd;
			want.level      = opening_steps[i].want_level;
			want.drive      = opening_steps[i].want_drive;
			send_item(it, opening_steps[i].known, want);
		end
		random_phase(600);
		drain();

		src_idle_pct = 54;
		snk_idle_pct = 10;
		hold_req = 1'b1;
		random_phase(650);
		drain();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		random_phase(650);
		drain();
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("** led_blink_fade_envelope_top: PASSED **");
		else
			$display("** led_blink_fade_envelope_top: FAILED **");
		$finish;
	end

	initial begin : receiver
		int unsigned hold_left;
		env_out_t    want;
		hold_left = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready) begin
				if (levels_due.size() == 0) begin
					$error("unexpected transfer: level %0d drive %0d",
						rsp_if.level, rsp_if.drive);
					mismatches++;
				end else begin
					want = levels_due.pop_front();
					if (rsp_if.level !== want.level) begin
						$error("level: expected %0d, got %0d", want.level, rsp_if.level);
						mismatches++;
					end
					if (rsp_if.drive !== want.drive) begin
						$error("drive: expected %0d, got %0d", want.drive, rsp_if.drive);
						mismatches++;
					end
				end
			end
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("** led_blink_fade_envelope_top: FAILED **");
				$finish;
			end
		end
	end

endmodule

>>> files.f
src/lbfe_pkg.sv
src/lbfe_in_if.sv
src/lbfe_out_if.sv
src/lbfe_scale.sv
src/led_blink_fade_envelope_top.sv
dv/tb.sv
